@@ sv/hsv_percent_to_rgb8_defines.svh @@
// Assertion macros for the top-level RTL file.
`ifndef HSV_PERCENT_TO_RGB8_DEFINES_SVH
`define HSV_PERCENT_TO_RGB8_DEFINES_SVH

`ifndef SYNTH
// Check on every rising edge of clk, masked while rst is high.
`define HSVRGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every rising edge of clk, reset included.
`define HSVRGB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSVRGB_ASSERT(lbl, prop, msg)
`define HSVRGB_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ sv/hsvrgb_pkg.sv @@
`default_nettype none

package hsvrgb_pkg;

  localparam logic [8:0] HueMax  = 9'd359;
  localparam logic [6:0] PctMax  = 7'd100;
  localparam logic [7:0] Full    = 8'd255;

  // x / 100 as x * 5243 >> 19, exact for x up to 25500
  localparam int Div100Mul   = 5243;
  // 425 * off / 100 folded into one constant multiply
  localparam int RampMul     = 425 * Div100Mul;

  // Hue sector, in order of increasing hue
  typedef enum logic [2:0] {
    SEC_RED_GREEN_UP,
    SEC_GREEN_RED_DOWN,
    SEC_GREEN_BLUE_UP,
    SEC_BLUE_GREEN_DOWN,
    SEC_BLUE_RED_UP,
    SEC_RED_BLUE_DOWN
  } sector_t;

  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] p;
    begin
      p = 28'(x) * 28'(Div100Mul);
      return p[26:19];
    end
  endfunction

  function automatic logic [7:0] ramp(input logic [5:0] off);
    logic [27:0] p;
    begin
      p = 28'(off) * 28'(RampMul);
      return p[26:19];
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/hsvrgb_chan.sv @@
`default_nettype none

module hsvrgb_chan import hsvrgb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [7:0] level_in,
  input  wire logic [6:0] inv_sat,
  input  wire logic [6:0] val,
  output logic      [7:0] level
);

  logic [14:0] lift;
  logic [7:0]  c3;
  logic [6:0]  v3;
  logic [7:0]  c4;
  logic [6:0]  v4;
  logic [14:0] scaled;

  always_ff @(posedge clk) begin
    if (en) begin
      // blend toward full scale: product first
      lift   <= 15'(Full - level_in) * 15'(inv_sat);
      c3     <= level_in;
      v3     <= val;
      // add the divided lift
      c4     <= c3 + div100(lift);
      v4     <= v3;
      // scale by value
      scaled <= 15'(c4) * 15'(v4);
      level  <= div100(scaled);
    end
  end

endmodule

`default_nettype wire

@@ sv/hsv_percent_to_rgb8.sv @@
`default_nettype none
// HSV to RGB converter for LED drive. Each input word carries hue in degrees
// and saturation and brightness in percent; values above 359, 100 and 100
// are clamped. Each output word carries 8-bit red, green and blue PWM duty
// levels, one output word per input word, in order. The datapath is a
// six-stage pipeline with no state between colors: one word is taken every
// cycle while the output side accepts. When the output word is not taken
// the whole pipeline holds, and the input side deasserts tready in the same
// cycle.

`include "hsv_percent_to_rgb8_defines.svh"

module hsv_percent_to_rgb8 import hsvrgb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // hue[8:0], saturation[15:9],
                                          // brightness[22:16], zero[23]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata   // red_level[7:0], green_level[15:8],
                                          // blue_level[23:16]
);

  localparam int Stages = 6;

  logic [Stages-1:0] vld;
  logic              en;

  // Stage 1 inputs
  logic [8:0] hue_in;
  logic [6:0] sat_in;
  logic [6:0] bri_in;
  logic [8:0] hue_c;
  logic [6:0] sat_c;
  logic [6:0] bri_c;
  sector_t    sector_next;
  logic [8:0] base_next;

  // Stage 1 registers
  sector_t    sector1;
  logic [5:0] off1;
  logic [6:0] inv1;
  logic [6:0] bri1;

  // Stage 2
  logic [7:0] rise;
  logic [7:0] fall;
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;
  logic [7:0] red2;
  logic [7:0] green2;
  logic [7:0] blue2;
  logic [6:0] inv2;
  logic [6:0] bri2;

  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;

  // Advance every stage unless the output word is stuck.
  assign en            = !vld[Stages-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Stages-1];
  assign m_axis_tdata  = {blue_level, green_level, red_level};

  assign hue_in = s_axis_tdata[8:0];
  assign sat_in = s_axis_tdata[15:9];
  assign bri_in = s_axis_tdata[22:16];

  // Clamp and pick the sector; each sector spans one breakpoint to the next.
  always_comb begin
    hue_c = (hue_in > HueMax) ? HueMax : hue_in;
    sat_c = (sat_in > PctMax) ? PctMax : sat_in;
    bri_c = (bri_in > PctMax) ? PctMax : bri_in;
    if (hue_c < 9'd61) begin
      sector_next = SEC_RED_GREEN_UP;
      base_next   = 9'd0;
    end else if (hue_c < 9'd121) begin
      sector_next = SEC_GREEN_RED_DOWN;
      base_next   = 9'd60;
    end else if (hue_c < 9'd181) begin
      sector_next = SEC_GREEN_BLUE_UP;
      base_next   = 9'd120;
    end else if (hue_c < 9'd241) begin
      sector_next = SEC_BLUE_GREEN_DOWN;
      base_next   = 9'd180;
    end else if (hue_c < 9'd301) begin
      sector_next = SEC_BLUE_RED_UP;
      base_next   = 9'd240;
    end else begin
      sector_next = SEC_RED_BLUE_DOWN;
      base_next   = 9'd300;
    end
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Stages-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector1 <= sector_next;
      off1    <= 6'(hue_c - base_next);  // offset within the sector, 0..60
      inv1    <= PctMax - sat_c;
      bri1    <= bri_c;
    end
  end

  // Stage 2: ramp value and channel assignment per sector.
  always_comb begin
    rise = ramp(off1);
    fall = Full - rise;
    unique case (sector1)
      SEC_RED_GREEN_UP: begin
        red_next = Full; green_next = rise; blue_next = 8'd0;
      end
      SEC_GREEN_RED_DOWN: begin
        red_next = fall; green_next = Full; blue_next = 8'd0;
      end
      SEC_GREEN_BLUE_UP: begin
        red_next = 8'd0; green_next = Full; blue_next = rise;
      end
      SEC_BLUE_GREEN_DOWN: begin
        red_next = 8'd0; green_next = fall; blue_next = Full;
      end
      SEC_BLUE_RED_UP: begin
        red_next = rise; green_next = 8'd0; blue_next = Full;
      end
      SEC_RED_BLUE_DOWN: begin
        red_next = Full; green_next = 8'd0; blue_next = fall;
      end
      default: begin
        red_next = 8'd0; green_next = 8'd0; blue_next = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red2   <= red_next;
      green2 <= green_next;
      blue2  <= blue_next;
      inv2   <= inv1;
      bri2   <= bri1;
    end
  end

  // Stages 3 to 6: saturation blend and brightness scaling per channel.
  hsvrgb_chan u_red (
    .clk      (clk),
    .en       (en),
    .level_in (red2),
    .inv_sat  (inv2),
    .val      (bri2),
    .level    (red_level)
  );

  hsvrgb_chan u_green (
    .clk      (clk),
    .en       (en),
    .level_in (green2),
    .inv_sat  (inv2),
    .val      (bri2),
    .level    (green_level)
  );

  hsvrgb_chan u_blue (
    .clk      (clk),
    .en       (en),
    .level_in (blue2),
    .inv_sat  (inv2),
    .val      (bri2),
    .level    (blue_level)
  );

  // A pure hue always has one channel at full scale and one at zero.
  `HSVRGB_ASSERT(a_hue_extremes, vld[1] |-> ((red2 == Full) || (green2 == Full) || (blue2 == Full)) && ((red2 == 8'd0) || (green2 == 8'd0) || (blue2 == 8'd0)), "hue stage lacks a full or a zero channel")
  // An accepted word enters the first stage.
  `HSVRGB_ASSERT(a_enter, s_axis_tvalid && s_axis_tready |=> vld[0], "accepted word lost at entry")
  // A stalled pipeline keeps every valid bit.
  `HSVRGB_ASSERT(a_stall_hold, !en |=> $stable(vld), "valid bits moved during a stall")
  // Reset empties the pipeline.
  `HSVRGB_ASSERT_RST(a_reset_empty, rst |=> (vld == '0), "pipeline not empty after reset")

endmodule

`default_nettype wire
